[hw/rtl/q2e_pkg.sv]
package q2e_pkg;

  // Field and datapath widths.
  localparam int unsigned SumW   = 34;  // sine and cosine terms, scaled by 2^30
  localparam int unsigned CordW  = 36;  // CORDIC x and y with room for gain
  localparam int unsigned AccW   = 32;  // angle accumulator, 2^31 equals pi
  localparam int unsigned RootW  = 31;  // square root result
  localparam int unsigned RemW   = 35;  // square root remainder
  localparam int unsigned RadW   = 62;  // square root radicand
  localparam int unsigned SqSteps = 31; // two radicand bits retire per step
  localparam int unsigned AtanLen = 24;

  localparam logic [AccW-1:0] HalfPiAcc  = 32'h4000_0000;
  localparam logic signed [15:0] HalfPiOut = 16'sd16384;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } q2e_in_t;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic               pitch_clamped;
  } q2e_out_t;

  // One CORDIC vector in flight.
  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic [AccW-1:0]         acc;
    logic                    zero;
  } q2e_lane_t;

  // One square root step in flight.
  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
    logic [RadW-1:0]  rad;
  } q2e_sqrt_t;

  // Arctangent of 2^-i in accumulator units.
  function automatic logic [AccW-1:0] q2e_atan(input int unsigned i);
    logic [AccW-1:0] r;
    unique case (i)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051D;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A30;
      19: r = 32'h00000518;
      20: r = 32'h0000028C;
      21: r = 32'h00000146;
      22: r = 32'h000000A3;
      23: r = 32'h00000051;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/q2e_sqrt_cell.sv]
module q2e_sqrt_cell
  import q2e_pkg::*;
(
  input  logic      clk_i,
  input  logic      en_i,
  input  q2e_sqrt_t sq_i,
  output q2e_sqrt_t sq_o
);

  logic [RemW-1:0] rem_sh;
  logic [RemW-1:0] trial;
  q2e_sqrt_t       sq_d;
  q2e_sqrt_t       sq_q;

  // Bring down the next two radicand bits and try the next root bit.
  always_comb begin
    rem_sh = {sq_i.rem[RemW-3:0], sq_i.rad[RadW-1 -: 2]};
    trial  = {2'b00, sq_i.root, 2'b01};
    sq_d.rad = {sq_i.rad[RadW-3:0], 2'b00};
    if (rem_sh >= trial) begin
      sq_d.rem  = rem_sh - trial;
      sq_d.root = {sq_i.root[RootW-2:0], 1'b1};
    end else begin
      sq_d.rem  = rem_sh;
      sq_d.root = {sq_i.root[RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= sq_d;
    end
  end

  assign sq_o = sq_q;

endmodule

[hw/rtl/q2e_cordic_cell.sv]
module q2e_cordic_cell
  import q2e_pkg::*;
#(
  parameter int unsigned STAGE = 0
) (
  input  logic      clk_i,
  input  logic      en_i,
  input  q2e_lane_t lane_i,
  output q2e_lane_t lane_o
);

  logic signed [CordW-1:0] x_sh;
  logic signed [CordW-1:0] y_sh;
  q2e_lane_t               lane_d;
  q2e_lane_t               lane_q;

  // One vectoring micro-rotation toward the positive x axis.
  always_comb begin
    x_sh = lane_i.x >>> STAGE;
    y_sh = lane_i.y >>> STAGE;
    lane_d.zero = lane_i.zero;
    if (lane_i.y >= 0) begin
      lane_d.x   = lane_i.x + y_sh;
      lane_d.y   = lane_i.y - x_sh;
      lane_d.acc = lane_i.acc + q2e_atan(STAGE);
    end else begin
      lane_d.x   = lane_i.x - y_sh;
      lane_d.y   = lane_i.y + x_sh;
      lane_d.acc = lane_i.acc - q2e_atan(STAGE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

[hw/rtl/quaternion_to_euler_angles.sv]
// Throughput: one beat per cycle while the output is not stalled; the square root
// and CORDIC chains are fully pipelined.
// The whole pipeline stalls together while an output beat waits to be taken.
// Reset clears only the valid bits; data registers are not reset.
module quaternion_to_euler_angles
  import q2e_pkg::*;
#(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  q2e_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output q2e_out_t out_data_o
);

  localparam int unsigned NStg  = (CORDIC_STAGES > AtanLen) ? AtanLen : CORDIC_STAGES;
  localparam int unsigned Lat   = 36 + NStg;

  typedef struct packed {
    logic signed [SumW-1:0] sr;
    logic signed [SumW-1:0] cr;
    logic signed [SumW-1:0] sy;
    logic signed [SumW-1:0] cy;
    logic signed [SumW-1:0] sp;
    logic                   clamp;
  } side_t;

  typedef struct packed {
    logic clamp;
    logic pos;
  } flag_t;

  logic            adv;
  logic [Lat-1:0]  vld_q;

  logic signed [31:0] p_wx_q, p_yz_q, p_xx_q, p_yy_q, p_wz_q, p_xy_q, p_zz_q, p_wy_q, p_zx_q;
  side_t              sum_q;
  side_t              side_s3_d;
  side_t              side_s3_q;
  logic [59:0]        sq_q;
  side_t              side_q [SqSteps];
  q2e_sqrt_t          sq_in;
  q2e_sqrt_t          sq_chain [SqSteps];
  q2e_lane_t          pre_q [3];
  q2e_lane_t          cd [NStg][3];
  flag_t              flag_q [NStg+1];
  logic [29:0]        sp_mag;
  q2e_out_t           out_q;

  assign adv        = !vld_q[Lat-1] || out_ready_i;
  assign in_ready_o = adv;
  assign out_valid_o = vld_q[Lat-1];
  assign out_data_o  = out_q;

  // Valid bits move with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
    end
  end

  // Products of the components, exact at 2^30 scale.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_wx_q <= in_data_i.quat_w * in_data_i.quat_x;
      p_yz_q <= in_data_i.quat_y * in_data_i.quat_z;
      p_xx_q <= in_data_i.quat_x * in_data_i.quat_x;
      p_yy_q <= in_data_i.quat_y * in_data_i.quat_y;
      p_wz_q <= in_data_i.quat_w * in_data_i.quat_z;
      p_xy_q <= in_data_i.quat_x * in_data_i.quat_y;
      p_zz_q <= in_data_i.quat_z * in_data_i.quat_z;
      p_wy_q <= in_data_i.quat_w * in_data_i.quat_y;
      p_zx_q <= in_data_i.quat_z * in_data_i.quat_x;
    end
  end

  // Sine and cosine terms.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sum_q.sr <= (SumW'(p_wx_q) + SumW'(p_yz_q)) <<< 1;
      sum_q.cr <= (SumW'(1) <<< 30) - ((SumW'(p_xx_q) + SumW'(p_yy_q)) <<< 1);
      sum_q.sy <= (SumW'(p_wz_q) + SumW'(p_xy_q)) <<< 1;
      sum_q.cy <= (SumW'(1) <<< 30) - ((SumW'(p_yy_q) + SumW'(p_zz_q)) <<< 1);
      sum_q.sp <= (SumW'(p_wy_q) - SumW'(p_zx_q)) <<< 1;
      sum_q.clamp <= 1'b0;
    end
  end

  // Saturation test and square of the pitch sine.
  always_comb begin
    if (sum_q.sp[SumW-1]) begin
      sp_mag = 30'(-sum_q.sp);
    end else begin
      sp_mag = 30'(sum_q.sp);
    end
  end

  always_comb begin
    side_s3_d       = sum_q;
    side_s3_d.clamp = (sum_q.sp >= (SumW'(1) <<< 30)) ||
                      (sum_q.sp <= -(SumW'(1) <<< 30));
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_s3_q <= side_s3_d;
      sq_q      <= sp_mag * sp_mag;
    end
  end

  // Square root of one minus the squared sine, two radicand bits per cell.
  always_comb begin
    sq_in.rem  = '0;
    sq_in.root = '0;
    sq_in.rad  = (RadW'(1) << 60) - RadW'(sq_q);
  end

  for (genvar k = 0; k < SqSteps; k++) begin : g_sqrt
    if (k == 0) begin : g_first
      q2e_sqrt_cell u_cell (.clk_i, .en_i(adv), .sq_i(sq_in), .sq_o(sq_chain[k]));
    end else begin : g_next
      q2e_sqrt_cell u_cell (.clk_i, .en_i(adv), .sq_i(sq_chain[k-1]), .sq_o(sq_chain[k]));
    end
  end

  // Side data rides along the square root chain.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side_s3_q;
      for (int k = 1; k < SqSteps; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // Half-plane rotation that starts each CORDIC lane.
  function automatic q2e_lane_t pre_rot(input logic signed [CordW-1:0] yv,
                                        input logic signed [CordW-1:0] xv);
    q2e_lane_t l;
    l.zero = (xv == 0) && (yv == 0);
    if (yv >= 0) begin
      l.x   = yv;
      l.y   = -xv;
      l.acc = HalfPiAcc;
    end else begin
      l.x   = -yv;
      l.y   = xv;
      l.acc = -HalfPiAcc;
    end
    return l;
  endfunction

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pre_q[0] <= pre_rot(CordW'(side_q[SqSteps-1].sr), CordW'(side_q[SqSteps-1].cr));
      pre_q[1] <= pre_rot(CordW'(side_q[SqSteps-1].sp),
                          $signed({{(CordW-RootW){1'b0}}, sq_chain[SqSteps-1].root}));
      pre_q[2] <= pre_rot(CordW'(side_q[SqSteps-1].sy), CordW'(side_q[SqSteps-1].cy));
      flag_q[0].clamp <= side_q[SqSteps-1].clamp;
      flag_q[0].pos   <= !side_q[SqSteps-1].sp[SumW-1];
      for (int k = 1; k <= NStg; k++) begin
        flag_q[k] <= flag_q[k-1];
      end
    end
  end

  // CORDIC chain: roll, pitch and yaw lanes side by side.
  for (genvar s = 0; s < NStg; s++) begin : g_cordic
    for (genvar l = 0; l < 3; l++) begin : g_lane
      if (s == 0) begin : g_first
        q2e_cordic_cell #(.STAGE(s)) u_cell (
          .clk_i, .en_i(adv), .lane_i(pre_q[l]), .lane_o(cd[s][l])
        );
      end else begin : g_next
        q2e_cordic_cell #(.STAGE(s)) u_cell (
          .clk_i, .en_i(adv), .lane_i(cd[s-1][l]), .lane_o(cd[s][l])
        );
      end
    end
  end

  // Round the accumulators to 16-bit angles.
  function automatic logic signed [15:0] to_angle(input q2e_lane_t l);
    logic [AccW-1:0] r;
    r = l.acc + 32'h0000_8000;
    return l.zero ? 16'sd0 : $signed(r[31:16]);
  endfunction

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.roll_angle    <= to_angle(cd[NStg-1][0]);
      out_q.yaw_angle     <= to_angle(cd[NStg-1][2]);
      out_q.pitch_clamped <= flag_q[NStg].clamp;
      if (flag_q[NStg].clamp) begin
        out_q.pitch_angle <= flag_q[NStg].pos ? HalfPiOut : -HalfPiOut;
      end else begin
        out_q.pitch_angle <= to_angle(cd[NStg-1][1]);
      end
    end
  end

  // A clamped pitch is exactly plus or minus half pi.
  a_clamp_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.pitch_clamped) |->
      (out_data_o.pitch_angle == HalfPiOut || out_data_o.pitch_angle == -HalfPiOut))
    else $error("clamped pitch is not half pi");

  // Pitch never leaves the half-pi range.
  a_pitch_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.pitch_angle <= HalfPiOut &&
                     out_data_o.pitch_angle >= -HalfPiOut))
    else $error("pitch out of range");

  // A stall freezes every valid bit in the pipeline.
  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline moved during stall");

endmodule

[dv/quaternion_to_euler_angles_tb.sv]
`timescale 1ns / 1ps

module quaternion_to_euler_angles_tb;
  import q2e_pkg::*;

  localparam int unsigned NumStages = 16;
  localparam int unsigned Latency   = NumStages + 36;
  localparam longint      CycleCap  = 400000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  q2e_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  q2e_out_t out_data_o;

  quaternion_to_euler_angles #(.CORDIC_STAGES(NumStages)) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  q2e_in_t  pending_quats[$];
  q2e_out_t expected_angles[$];
  int       error_count = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  bit       hold_sender = 1'b0;
  longint   cycle_count = 0;

  // Arctangent of 2^-i in accumulator units; the 32-bit angle wraps at 2*pi.
  function automatic logic [31:0] atan_step(int unsigned i);
    logic [31:0] steps [24];
    steps = '{32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
              32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
              32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
              32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
              32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
              32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
    return steps[i];
  endfunction

  // Vectoring CORDIC with a half-plane pre-rotation; result rounded half up.
  function automatic logic [15:0] vector_angle(longint sy, longint sx);
    longint      cx, cy, nx, ny;
    logic [31:0] acc;
    logic [31:0] rounded;
    if (sx == 0 && sy == 0) return 16'h0;
    if (sy >= 0) begin
      cx = sy; cy = -sx; acc = 32'h4000_0000;
    end else begin
      cx = -sy; cy = sx; acc = 32'hC000_0000;
    end
    for (int i = 0; i < NumStages && i < 24; i++) begin
      if (cy >= 0) begin
        nx = cx + (cy >>> i); ny = cy - (cx >>> i); acc += atan_step(i);
      end else begin
        nx = cx - (cy >>> i); ny = cy + (cx >>> i); acc -= atan_step(i);
      end
      cx = nx; cy = ny;
    end
    rounded = acc + 32'h8000;
    return rounded[31:16];
  endfunction

  // Integer floor square root, two radicand bits per step.
  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > n) bit_w >>= 2;
    while (bit_w != 0) begin
      if (n >= res + bit_w) begin
        n -= res + bit_w; res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return res;
  endfunction

  function automatic q2e_out_t euler_of(q2e_in_t q);
    longint   w, x, y, z, sr, cr, sy, cyw, sp, cp;
    longint   one;
    q2e_out_t r;
    w = q.quat_w; x = q.quat_x; y = q.quat_y; z = q.quat_z;
    one = 64'sd1 << 30;
    sr  = 2 * (w * x + y * z);
    cr  = one - 2 * (x * x + y * y);
    sy  = 2 * (w * z + x * y);
    cyw = one - 2 * (y * y + z * z);
    sp  = 2 * (w * y - z * x);
    r.roll_angle = vector_angle(sr, cr);
    r.yaw_angle  = vector_angle(sy, cyw);
    if (sp >= one) begin
      r.pitch_angle = 16'sd16384; r.pitch_clamped = 1'b1;
    end else if (sp <= -one) begin
      r.pitch_angle = -16'sd16384; r.pitch_clamped = 1'b1;
    end else begin
      cp = longint'(floor_sqrt((64'd1 << 60) - longint'(sp * sp)));
      r.pitch_angle = vector_angle(sp, cp);
      r.pitch_clamped = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'(int'($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  // Random unit-ish quaternion: random direction scaled toward norm one.
  function automatic q2e_in_t rand_unit_quat();
    real     a, b, c, d, n;
    q2e_in_t q;
    a = real'(int'($urandom_range(0, 2000)) - 1000);
    b = real'(int'($urandom_range(0, 2000)) - 1000);
    c = real'(int'($urandom_range(0, 2000)) - 1000);
    d = real'(int'($urandom_range(0, 2000)) - 1000);
    n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
    q.quat_w = 16'($rtoi(a / n * 32767.0));
    q.quat_x = 16'($rtoi(b / n * 32767.0));
    q.quat_y = 16'($rtoi(c / n * 32767.0));
    q.quat_z = 16'($rtoi(d / n * 32767.0));
    return q;
  endfunction

  // Beat driver: presents queued quaternions, idling at random.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_angles.push_back(euler_of(in_data_i));
      end
      if (!(in_valid_i && !in_ready_o)) begin
        if (pending_quats.size() > 0 && !hold_sender &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          in_data_i  <= pending_quats.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Result monitor: compares every output beat against the oldest prediction.
  always @(posedge clk_i) begin
    q2e_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_angles.size() == 0) begin
        report_mismatch("unexpected beat", 0, 0);
      end else begin
        want = expected_angles.pop_front();
        if (out_data_o.roll_angle !== want.roll_angle)
          report_mismatch("roll", out_data_o.roll_angle, want.roll_angle);
        if (out_data_o.pitch_angle !== want.pitch_angle)
          report_mismatch("pitch", out_data_o.pitch_angle, want.pitch_angle);
        if (out_data_o.yaw_angle !== want.yaw_angle)
          report_mismatch("yaw", out_data_o.yaw_angle, want.yaw_angle);
        if (out_data_o.pitch_clamped !== want.pitch_clamped)
          report_mismatch("clamp", out_data_o.pitch_clamped, want.pitch_clamped);
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleCap) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic q2e_in_t mk(int w, int x, int y, int z);
    q2e_in_t q;
    q.quat_w = 16'(w); q.quat_x = 16'(x); q.quat_y = 16'(y); q.quat_z = 16'(z);
    return q;
  endfunction

  task automatic wait_drained();
    while (pending_quats.size() > 0 || in_valid_i || expected_angles.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    q2e_in_t q;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: identity, extremes, zero vector, pitch near the clamp both ways,
    // angles near +pi that wrap, and unnormalized input.
    pending_quats.push_back(mk(32767, 0, 0, 0));
    pending_quats.push_back(mk(0, 0, 0, 0));
    pending_quats.push_back(mk(-32768, -32768, -32768, -32768));
    pending_quats.push_back(mk(32767, 32767, 32767, 32767));
    pending_quats.push_back(mk(23170, 0, 23170, 0));
    pending_quats.push_back(mk(23170, 0, -23170, 0));
    pending_quats.push_back(mk(23170, 0, 23169, 0));
    pending_quats.push_back(mk(0, 32767, 0, 0));
    pending_quats.push_back(mk(0, 0, 0, 32767));
    pending_quats.push_back(mk(0, 0, 32767, 0));
    pending_quats.push_back(mk(1, -32768, 0, 0));
    pending_quats.push_back(mk(-1, -32768, 0, 0));
    pending_quats.push_back(mk(32767, -32768, 32767, -32768));
    pending_quats.push_back(mk(-32768, 32767, -32768, 32767));
    pending_quats.push_back(mk(16384, 16384, 16384, 16384));
    pending_quats.push_back(mk(100, 0, 0, 0));
    pending_quats.push_back(mk(0, 23170, 0, 23170));
    pending_quats.push_back(mk(-32768, 0, 0, 0));

    // Random phases with different idling profiles.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 50 : 0;
      recv_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 34 : 0;
      for (int n = 0; n < 650; n++) begin
        if ($urandom_range(0, 3) == 0) begin
          q.quat_w = rand_comp(); q.quat_x = rand_comp();
          q.quat_y = rand_comp(); q.quat_z = rand_comp();
        end else begin
          q = rand_unit_quat();
        end
        pending_quats.push_back(q);
        if (n == 300) begin
          // Send what is queued, then hold off until every result is back.
          while (pending_quats.size() > 0) @(posedge clk_i);
          hold_sender = 1'b1;
          while (in_valid_i || expected_angles.size() > 0) @(posedge clk_i);
          hold_sender = 1'b0;
        end
      end
      wait_drained();
    end

    repeat (Latency + 10) @(posedge clk_i);
    if (error_count == 0 && expected_angles.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
